### design/swadc_pkg.sv
package swadc_pkg;

  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 128;
  localparam int MAX_RADIUS = 8;

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam int X_W        = 7;
  localparam int PIX_W      = 8;
  localparam int RGB_W      = 3 * PIX_W;
  localparam int SIZE_W     = 8;
  localparam int RADIUS_W   = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int COST_W     = 42;
  localparam int COUNT_W    = 8;
  localparam int COUNT_MAX  = 255;

  localparam int CW       = 10;
  localparam int MAX_SPAN = 2 * MAX_RADIUS - 1;
  localparam int MAX_POS  = MAX_SPAN * MAX_SPAN;
  localparam int OW       = $clog2(2 * MAX_RADIUS);
  localparam int CNT_W    = $clog2(MAX_POS + 2);
  localparam int SUM_W    = PIX_W + $clog2(MAX_POS + 1);
  localparam int PROD_W   = 2 * SUM_W;
  localparam int SQ_W     = PROD_W + 2;
  localparam int DEN_W    = 2 * CNT_W;
  localparam int FRAC_BITS = 8;
  localparam int NUM_W    = SQ_W + FRAC_BITS;
  localparam int QW       = (NUM_W > COST_W) ? NUM_W : COST_W;
  localparam int DIV_CNT_W = $clog2(QW);

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd2;

  localparam int MUL_W = 3;
  localparam logic [MUL_W-1:0] MUL_RED   = 3'd0;
  localparam logic [MUL_W-1:0] MUL_GREEN = 3'd1;
  localparam logic [MUL_W-1:0] MUL_BLUE  = 3'd2;
  localparam logic [MUL_W-1:0] MUL_COUNT = 3'd3;
  localparam logic [MUL_W-1:0] MUL_LOAD  = 3'd4;

  typedef struct packed {
    logic             mode;
    logic [X_W-1:0]   x;
    logic [X_W-1:0]   y;
    logic [X_W-1:0]   disparity;
    logic [PIX_W-1:0] left_red;
    logic [PIX_W-1:0] left_green;
    logic [PIX_W-1:0] left_blue;
    logic [PIX_W-1:0] right_red;
    logic [PIX_W-1:0] right_green;
    logic [PIX_W-1:0] right_blue;
  } swadc_item_t;

  typedef struct packed {
    logic             load_wr;
    logic             query_start;
    logic             walk;
    logic             mul_en;
    logic [MUL_W-1:0] mul_sel;
    logic             div_en;
    logic             load_out;
  } swadc_cmd_t;

  typedef struct packed {
    logic radius_zero;
    logic walk_last;
    logic out_free;
  } swadc_sts_t;

endpackage

### design/swadc_intf.sv
interface swadc_in_if import swadc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             mode;
  logic [X_W-1:0]   x;
  logic [X_W-1:0]   y;
  logic [X_W-1:0]   disparity;
  logic [PIX_W-1:0] left_red;
  logic [PIX_W-1:0] left_green;
  logic [PIX_W-1:0] left_blue;
  logic [PIX_W-1:0] right_red;
  logic [PIX_W-1:0] right_green;
  logic [PIX_W-1:0] right_blue;

  modport source (
    output valid, mode, x, y, disparity, left_red, left_green, left_blue,
    output right_red, right_green, right_blue,
    input  ready
  );
  modport sink (
    input  valid, mode, x, y, disparity, left_red, left_green, left_blue,
    input  right_red, right_green, right_blue,
    output ready
  );
endinterface

interface swadc_out_if import swadc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COST_W-1:0]  cost;
  logic [COUNT_W-1:0] pixel_count;

  modport source (output valid, cost, pixel_count, input ready);
  modport sink (input valid, cost, pixel_count, output ready);
endinterface

### design/swadc_ctrl.sv
module swadc_ctrl import swadc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_mode,
  output logic       in_ready,
  input  swadc_sts_t sts,
  output swadc_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WALK  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(QW - 1);

  logic [2:0]           state_r, state_nxt;
  logic [MUL_W-1:0]     mul_cnt_r, mul_cnt_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic                 accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd             = '0;
    cmd.load_wr     = accept && (in_mode == MODE_LOAD);
    cmd.query_start = accept && (in_mode == MODE_QUERY);
    cmd.walk        = (state_r == S_WALK);
    cmd.mul_en      = (state_r == S_MUL);
    cmd.mul_sel     = mul_cnt_r;
    cmd.div_en      = (state_r == S_DIV);
    cmd.load_out    = (state_r == S_OUT) && sts.out_free;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.query_start) begin
          state_nxt = sts.radius_zero ? S_MUL : S_WALK;
        end
      end
      S_WALK: begin
        if (sts.walk_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: state_nxt = S_MUL;
      S_MUL: begin
        if (mul_cnt_r == MUL_LOAD) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_cnt_r == DIV_LAST) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign mul_cnt_nxt = ((state_r == S_MUL) && (mul_cnt_r != MUL_LOAD)) ?
                       mul_cnt_r + 1'b1 : MUL_RED;
  assign div_cnt_nxt = ((state_r == S_DIV) && (div_cnt_r != DIV_LAST)) ?
                       div_cnt_r + 1'b1 : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      mul_cnt_r <= MUL_RED;
      div_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      mul_cnt_r <= mul_cnt_nxt;
      div_cnt_r <= div_cnt_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_walk_to_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) && sts.walk_last |=> (state_r == S_DRAIN))
    else $error("Window walk did not end in the drain state.");

  a_drain_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) |=> (state_r == S_MUL) && (mul_cnt_r == MUL_RED))
    else $error("Squaring did not start from the first step.");

  a_full_divide: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) && ($past(state_r) == S_DIV) |-> ($past(div_cnt_r) == DIV_LAST))
    else $error("Division left before all quotient bits were formed.");

  a_no_transfer_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !(cmd.load_wr || cmd.query_start))
    else $error("Input transfer taken while a query is in progress.");
`endif

endmodule

### design/swadc_datapath.sv
module swadc_datapath import swadc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  swadc_cmd_t            cmd,
  output swadc_sts_t            sts,
  input  swadc_item_t           item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COST_W-1:0]     out_cost,
  output logic [COUNT_W-1:0]    out_pixel_count
);

  function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  logic [SIZE_W-1:0]   width_r, height_r;
  logic [RADIUS_W-1:0] radius_r;

  logic [SIZE_W-1:0]   w_eff, h_eff;
  logic [RADIUS_W-1:0] r_eff;

  logic signed [CW-1:0] bx_r, by_r;
  logic [X_W-1:0]       disp_r;
  logic [OW-1:0]        span_m1_r, ox_r, oy_r;

  logic signed [CW-1:0] cx, cy, rx, w_s, h_s;
  logic                 pos_valid;
  logic [ADDR_W-1:0]    rd_addr_l, rd_addr_r, wr_addr;
  logic                 load_ok;

  logic [RGB_W-1:0] left_mem [DEPTH];
  logic [RGB_W-1:0] right_mem [DEPTH];
  logic [RGB_W-1:0] left_rd_r, right_rd_r;
  logic             rd_valid_r;

  logic [SUM_W-1:0]  sr_r, sg_r, sb_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [SUM_W-1:0]  mul_a;
  logic [PROD_W-1:0] prod_r;
  logic [SQ_W-1:0]   sq_r;
  logic [DEN_W-1:0]  den_r, rem_r, rem_nxt;
  logic [QW-1:0]     q_r;
  logic [DEN_W:0]    rem_sh, rem_sub;
  logic              rem_ge;

  logic               out_valid_r;
  logic [COST_W-1:0]  out_cost_r;
  logic [COUNT_W-1:0] out_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIZE_W'(128);
      height_r <= SIZE_W'(128);
      radius_r <= RADIUS_W'(7);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_data;
        CFG_HEIGHT: height_r <= cfg_data;
        CFG_RADIUS: radius_r <= cfg_data[RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  assign w_eff = (32'(width_r) > MAX_WIDTH) ? SIZE_W'(MAX_WIDTH) : width_r;
  assign h_eff = (32'(height_r) > MAX_HEIGHT) ? SIZE_W'(MAX_HEIGHT) : height_r;
  assign r_eff = (32'(radius_r) > MAX_RADIUS) ? RADIUS_W'(MAX_RADIUS) : radius_r;

  assign sts.radius_zero = (r_eff == '0);
  assign sts.walk_last   = (ox_r == span_m1_r) && (oy_r == span_m1_r);
  assign sts.out_free    = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      bx_r      <= $signed(CW'(item.x)) - $signed(CW'(r_eff)) + $signed(CW'(1));
      by_r      <= $signed(CW'(item.y)) - $signed(CW'(r_eff)) + $signed(CW'(1));
      disp_r    <= item.disparity;
      span_m1_r <= OW'(32'(r_eff) * 2 - 2);
      ox_r      <= '0;
      oy_r      <= '0;
    end else if (cmd.walk) begin
      if (oy_r == span_m1_r) begin
        oy_r <= '0;
        ox_r <= ox_r + 1'b1;
      end else begin
        oy_r <= oy_r + 1'b1;
      end
    end
  end

  assign cx  = bx_r + $signed(CW'(ox_r));
  assign cy  = by_r + $signed(CW'(oy_r));
  assign rx  = cx - $signed(CW'(disp_r));
  assign w_s = $signed(CW'(w_eff));
  assign h_s = $signed(CW'(h_eff));

  assign pos_valid = (cx > 0) && (cx < w_s) && (cy > 0) && (cy < h_s) &&
                     (rx > 0) && (rx < w_s);

  assign rd_addr_l = ADDR_W'(32'($unsigned(cy)) * MAX_WIDTH + 32'($unsigned(cx)));
  assign rd_addr_r = ADDR_W'(32'($unsigned(cy)) * MAX_WIDTH + 32'($unsigned(rx)));
  assign wr_addr   = ADDR_W'(32'(item.y) * MAX_WIDTH + 32'(item.x));
  assign load_ok   = (32'(item.x) < MAX_WIDTH) && (32'(item.y) < MAX_HEIGHT);

  always_ff @(posedge clk) begin
    if (cmd.load_wr && load_ok) begin
      left_mem[wr_addr] <= {item.left_red, item.left_green, item.left_blue};
    end
    left_rd_r <= left_mem[rd_addr_l];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_wr && load_ok) begin
      right_mem[wr_addr] <= {item.right_red, item.right_green, item.right_blue};
    end
    right_rd_r <= right_mem[rd_addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= cmd.walk && pos_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      sr_r  <= '0;
      sg_r  <= '0;
      sb_r  <= '0;
      cnt_r <= CNT_W'(1);
    end else if (rd_valid_r) begin
      sr_r  <= sr_r + SUM_W'(abs_diff(left_rd_r[23:16], right_rd_r[23:16]));
      sg_r  <= sg_r + SUM_W'(abs_diff(left_rd_r[15:8], right_rd_r[15:8]));
      sb_r  <= sb_r + SUM_W'(abs_diff(left_rd_r[7:0], right_rd_r[7:0]));
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_comb begin
    unique case (cmd.mul_sel)
      MUL_RED:   mul_a = sr_r;
      MUL_GREEN: mul_a = sg_r;
      MUL_BLUE:  mul_a = sb_r;
      MUL_COUNT: mul_a = SUM_W'(cnt_r);
      default:   mul_a = '0;
    endcase
  end

  assign rem_sh  = {rem_r, q_r[QW-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign rem_ge  = (rem_sh >= {1'b0, den_r});
  assign rem_nxt = rem_ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= mul_a * mul_a;
      unique case (cmd.mul_sel)
        MUL_RED: sq_r <= '0;
        MUL_GREEN, MUL_BLUE, MUL_COUNT: sq_r <= sq_r + SQ_W'(prod_r);
        MUL_LOAD: begin
          den_r <= prod_r[DEN_W-1:0];
          q_r   <= QW'(sq_r) << FRAC_BITS;
          rem_r <= '0;
        end
        default: ;
      endcase
    end else if (cmd.div_en) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[QW-2:0], rem_ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_cost_r  <= q_r[COST_W-1:0];
      out_count_r <= (32'(cnt_r) > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : COUNT_W'(cnt_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_cost        = out_cost_r;
  assign out_pixel_count = out_count_r;

endmodule

### design/stereo_window_abs_diff_cost_core.sv
// Stereo window matching cost engine. A load transfer (mode 0) writes one left and one right
// RGB pixel at (x,y); loads may follow each other in every cycle between queries. A query
// transfer (mode 1) sums absolute left-minus-shifted-right differences per channel over the
// square window of half-size radius-1 around (x,y), counting only positions whose column,
// row and shifted column fall strictly inside the image, and returns (R^2+G^2+B^2)/count^2
// with 8 fraction bits together with the count, counted positions plus one. A query holds
// the block until its result is in the output register (at radius 0 the walk and its drain
// state are skipped): the window is walked one position per cycle through the single read
// port of each pixel memory, four squarings share one multiplier, and the quotient comes
// from a restoring divider that forms one bit per cycle. The next input transfer is taken as
// soon as the result sits in the output register. The user must write configuration through
// cfg_we/cfg_index/cfg_data only while the block is idle; the block does not enforce it.
module stereo_window_abs_diff_cost_core import swadc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  swadc_in_if.sink              in_ch,
  swadc_out_if.source           out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  swadc_cmd_t  cmd;
  swadc_sts_t  sts;
  swadc_item_t item;
  logic        in_ready;

  assign item.mode        = in_ch.mode;
  assign item.x           = in_ch.x;
  assign item.y           = in_ch.y;
  assign item.disparity   = in_ch.disparity;
  assign item.left_red    = in_ch.left_red;
  assign item.left_green  = in_ch.left_green;
  assign item.left_blue   = in_ch.left_blue;
  assign item.right_red   = in_ch.right_red;
  assign item.right_green = in_ch.right_green;
  assign item.right_blue  = in_ch.right_blue;

  assign in_ch.ready = in_ready;

  swadc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_mode  (in_ch.mode),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  swadc_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .item            (item),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_cost        (out_ch.cost),
    .out_pixel_count (out_ch.pixel_count)
  );

endmodule

### verif/stereo_window_abs_diff_cost_core_tb.sv
`timescale 1ns / 100ps

import swadc_pkg::*;

class cost_scoreboard;
  typedef struct {
    logic [COST_W-1:0]  cost;
    logic [COUNT_W-1:0] pixel_count;
  } window_cost_t;

  logic [RGB_W-1:0] left_img [DEPTH];
  logic [RGB_W-1:0] right_img [DEPTH];
  bit               loaded [DEPTH];
  int unsigned      image_width;
  int unsigned      image_height;
  int unsigned      window_radius;
  window_cost_t     pending_costs [$];
  int               errors;
  int               loads;
  int               queries;
  int               matched;

  function new();
    image_width   = MAX_WIDTH;
    image_height  = MAX_HEIGHT;
    window_radius = 7;
  endfunction

  task report(string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    case (index)
      CFG_WIDTH:  image_width = 32'(data);
      CFG_HEIGHT: image_height = 32'(data);
      CFG_RADIUS: window_radius = 32'(data[RADIUS_W-1:0]);
      default: ;
    endcase
  endfunction

  function void window_limits(output int w, output int h, output int r);
    w = (image_width > MAX_WIDTH) ? MAX_WIDTH : image_width;
    h = (image_height > MAX_HEIGHT) ? MAX_HEIGHT : image_height;
    r = (window_radius > MAX_RADIUS) ? MAX_RADIUS : window_radius;
  endfunction

  function bit counted(int cx, int cy, int rx, int w, int h);
    return cy > 0 && cy < h && cx > 0 && cx < w && rx > 0 && rx < w;
  endfunction

  // A query is only issued when every pixel it will read has been loaded.
  function bit query_is_safe(int x, int y, int d);
    int w, h, r;
    window_limits(w, h, r);
    for (int cx = x - r + 1; cx <= x + r - 1; cx++) begin
      for (int cy = y - r + 1; cy <= y + r - 1; cy++) begin
        if (counted(cx, cy, cx - d, w, h) &&
            !(loaded[ADDR_W'(cy * MAX_WIDTH + cx)] &&
              loaded[ADDR_W'(cy * MAX_WIDTH + cx - d)]))
          return 0;
      end
    end
    return 1;
  endfunction

  function longint unsigned chan_diff(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
    return 64'((a > b) ? a - b : b - a);
  endfunction

  function void note_input(swadc_item_t it);
    int                w, h, r;
    logic [ADDR_W-1:0] addr, raddr;
    longint unsigned   sr, sg, sb, cnt, sq, quotient;
    logic [RGB_W-1:0]  lp, rp;
    window_cost_t      expected;
    if (it.mode == MODE_LOAD) begin
      addr = ADDR_W'(it.y * MAX_WIDTH + it.x);
      left_img[addr]  = {it.left_red, it.left_green, it.left_blue};
      right_img[addr] = {it.right_red, it.right_green, it.right_blue};
      loaded[addr]    = 1;
      loads++;
      return;
    end
    queries++;
    window_limits(w, h, r);
    sr = 0;
    sg = 0;
    sb = 0;
    cnt = 1;
    for (int cx = int'(it.x) - r + 1; cx <= int'(it.x) + r - 1; cx++) begin
      for (int cy = int'(it.y) - r + 1; cy <= int'(it.y) + r - 1; cy++) begin
        if (counted(cx, cy, cx - int'(it.disparity), w, h)) begin
          addr  = ADDR_W'(cy * MAX_WIDTH + cx);
          raddr = ADDR_W'(cy * MAX_WIDTH + cx - int'(it.disparity));
          lp = left_img[addr];
          rp = right_img[raddr];
          sr += chan_diff(lp[23:16], rp[23:16]);
          sg += chan_diff(lp[15:8], rp[15:8]);
          sb += chan_diff(lp[7:0], rp[7:0]);
          cnt++;
        end
      end
    end
    sq = sr * sr + sg * sg + sb * sb;
    quotient = (sq << FRAC_BITS) / (cnt * cnt);
    expected.cost        = quotient[COST_W-1:0];
    expected.pixel_count = (cnt > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : cnt[COUNT_W-1:0];
    pending_costs = {pending_costs, expected};
  endfunction

  task check_result(logic [COST_W-1:0] cost, logic [COUNT_W-1:0] pixel_count);
    window_cost_t expected;
    if (pending_costs.size() == 0) begin
      report($sformatf("result cost=%0d count=%0d with no query waiting", cost, pixel_count));
      return;
    end
    expected = pending_costs.pop_front();
    matched++;
    if (cost !== expected.cost)
      report($sformatf("cost %0d, expected %0d", cost, expected.cost));
    if (pixel_count !== expected.pixel_count)
      report($sformatf("pixel_count %0d, expected %0d", pixel_count, expected.pixel_count));
  endtask
endclass

module stereo_window_abs_diff_cost_core_tb;
  localparam int QUIET_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 600;
  localparam int SETTLE_CYCLES = 300;
  localparam int PHASE_ITEMS   = 37;
  localparam int PHASES        = 22;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  swadc_in_if  in_bus ();
  swadc_out_if out_bus ();

  stereo_window_abs_diff_cost_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  cost_scoreboard costs = new();
  bit             no_idle = 0;
  bit             hold_request = 0;
  int             quiet_cycles = 0;
  int             settings_used = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    in_bus.valid       = 1'b0;
    in_bus.mode        = MODE_LOAD;
    in_bus.x           = '0;
    in_bus.y           = '0;
    in_bus.disparity   = '0;
    in_bus.left_red    = '0;
    in_bus.left_green  = '0;
    in_bus.left_blue   = '0;
    in_bus.right_red   = '0;
    in_bus.right_green = '0;
    in_bus.right_blue  = '0;
    out_bus.ready      = 1'b0;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 50)
      return 0;
    if (roll < 90)
      return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10)
      return '0;
    if (roll < 20)
      return '1;
    return PIX_W'($urandom_range(0, 255));
  endfunction

  function automatic swadc_item_t load_item(int x, int y, logic [RGB_W-1:0] left,
                                            logic [RGB_W-1:0] right);
    swadc_item_t it;
    it.mode        = MODE_LOAD;
    it.x           = X_W'(x);
    it.y           = X_W'(y);
    it.disparity   = X_W'($urandom_range(0, 127));
    it.left_red    = left[23:16];
    it.left_green  = left[15:8];
    it.left_blue   = left[7:0];
    it.right_red   = right[23:16];
    it.right_green = right[15:8];
    it.right_blue  = right[7:0];
    return it;
  endfunction

  function automatic swadc_item_t query_item(int x, int y, int d);
    swadc_item_t it;
    it = load_item(x, y, RGB_W'($urandom), RGB_W'($urandom));
    it.mode      = MODE_QUERY;
    it.disparity = X_W'(d);
    return it;
  endfunction

  // Loads land mostly on the two corner patches that queries read from; queries are
  // drawn, for at most 40 tries, until every pixel their window reads has been loaded.
  function automatic swadc_item_t random_item();
    swadc_item_t it;
    int          roll, x, y, d;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
        x = $urandom_range(0, 23);
        y = $urandom_range(0, 23);
      end else if (roll < 60) begin
        x = $urandom_range(112, 127);
        y = $urandom_range(112, 127);
      end else begin
        x = $urandom_range(0, 127);
        y = $urandom_range(0, 127);
      end
      return load_item(x, y, {pick_pixel(), pick_pixel(), pick_pixel()},
                       {pick_pixel(), pick_pixel(), pick_pixel()});
    end
    for (int tries = 0; tries < 40; tries++) begin
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
        x = $urandom_range(0, 23);
        y = $urandom_range(0, 23);
        d = $urandom_range(0, 24);
      end else if (roll < 85) begin
        x = $urandom_range(112, 127);
        y = $urandom_range(112, 127);
        d = $urandom_range(0, 16);
      end else begin
        x = $urandom_range(0, 127);
        y = $urandom_range(0, 127);
        d = $urandom_range(0, 127);
      end
      if (costs.query_is_safe(x, y, d))
        return query_item(x, y, d);
    end
    return query_item(0, 0, 127);
  endfunction

  task automatic send_item(swadc_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.mode        <= it.mode;
    in_bus.x           <= it.x;
    in_bus.y           <= it.y;
    in_bus.disparity   <= it.disparity;
    in_bus.left_red    <= it.left_red;
    in_bus.left_green  <= it.left_green;
    in_bus.left_blue   <= it.left_blue;
    in_bus.right_red   <= it.right_red;
    in_bus.right_green <= it.right_green;
    in_bus.right_blue  <= it.right_blue;
    in_bus.valid       <= 1'b1;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    costs.note_input(it);
  endtask

  task automatic settle();
    in_bus.valid <= 1'b0;
    while (costs.pending_costs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(int w, int h, int r);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WIDTH;
    cfg_data  <= CFG_DATA_W'(w);
    @(posedge clk);
    costs.set_register(CFG_WIDTH, CFG_DATA_W'(w));
    cfg_index <= CFG_HEIGHT;
    cfg_data  <= CFG_DATA_W'(h);
    @(posedge clk);
    costs.set_register(CFG_HEIGHT, CFG_DATA_W'(h));
    cfg_index <= CFG_RADIUS;
    cfg_data  <= CFG_DATA_W'(r);
    @(posedge clk);
    costs.set_register(CFG_RADIUS, CFG_DATA_W'(r));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin : result_sink
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 0;
        stall = HOLD_CYCLES;
      end else begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      @(posedge clk);
      while (!out_bus.valid) @(posedge clk);
      costs.check_result(out_bus.cost, out_bus.pixel_count);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("no transfer for %0d cycles, giving up", QUIET_LIMIT);
        $display("stereo_window_abs_diff_cost_core_tb: errors");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int phase_w[11] = '{128, 24, 2, 0, 1, 255, 200, 16, 128, 2, 3};
    int phase_h[11] = '{128, 24, 2, 0, 5, 255, 129, 20, 2, 128, 128};
    int phase_r[11] = '{8, 8, 1, 3, 2, 15, 9, 0, 4, 5, 2};
    int w, h, r;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int y = 0; y < 24; y++)
      for (int x = 0; x < 24; x++)
        send_item(load_item(x, y, RGB_W'($urandom), RGB_W'($urandom)));
    for (int y = 112; y < 128; y++)
      for (int x = 112; x < 128; x++)
        send_item(load_item(x, y, RGB_W'($urandom), RGB_W'($urandom)));

    // Directed items run at the settings left by reset.
    send_item(load_item(0, 0, 24'hFFFFFF, 24'h000000));
    send_item(load_item(1, 1, 24'h000000, 24'hFFFFFF));
    send_item(load_item(12, 12, 24'hFF00FF, 24'h00FF00));
    send_item(load_item(23, 23, 24'h0F0F0F, 24'hF0F0F0));
    send_item(load_item(127, 127, 24'hFFFFFF, 24'h000000));
    send_item(load_item(5, 5, 24'hFFFFFF, 24'hFFFFFF));
    send_item(query_item(0, 0, 0));
    send_item(query_item(0, 0, 127));
    send_item(query_item(1, 1, 0));
    send_item(query_item(1, 1, 1));
    send_item(query_item(12, 12, 0));
    send_item(query_item(12, 12, 12));
    send_item(query_item(10, 8, 5));
    send_item(query_item(16, 16, 2));
    send_item(query_item(127, 127, 0));
    send_item(query_item(127, 127, 127));
    send_item(query_item(120, 120, 2));
    send_item(query_item(124, 124, 4));
    settle();

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase < 11) begin
        w = phase_w[phase];
        h = phase_h[phase];
        r = phase_r[phase];
      end else begin
        w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(2, 128);
        h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(2, 128);
        r = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
      end
      apply_settings(w, h, r);
      no_idle = (phase % 4 == 2);
      if (phase == 0)
        hold_request = 1;
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_item(random_item());
      settle();
    end

    $display("%0d loads and %0d queries under %0d register settings;",
             costs.loads, costs.queries, settings_used);
    $display("%0d cost results compared, including a long output stall", costs.matched);
    if (costs.errors == 0)
      $display("stereo_window_abs_diff_cost_core_tb: clean");
    else
      $display("stereo_window_abs_diff_cost_core_tb: errors");
    $finish;
  end
endmodule
